/* src/indexed_list_insert_delete_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list
// Concurrent checks on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// cond holds in the same cycle as ante
`define ILID_ASSERT_SAME(lbl, ante, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cond)) \
    else $error("ilid assertion failed");

// cond holds in the cycle after ante
`define ILID_ASSERT_NEXT(lbl, ante, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cond)) \
    else $error("ilid assertion failed");

`else

`define ILID_ASSERT_SAME(lbl, ante, cond)
`define ILID_ASSERT_NEXT(lbl, ante, cond)

`endif

`endif

/* src/ilid_pkg.sv */
// ---------------------------------------------------------------------------
// ilid_pkg
// Shared constants and types of the indexed list.
// ---------------------------------------------------------------------------
package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_DELETE = 3'd2,
    FN_CLEAR  = 3'd3,
    FN_READ   = 3'd4,
    FN_WRITE  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_SHIFT_R = 2'd2,
    OP_SHIFT_L = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [CMP_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

/* src/ilid_cell.sv */
// ---------------------------------------------------------------------------
// ilid_cell
// One list entry; loads its own word, its left or its right neighbor's word.
// ---------------------------------------------------------------------------
module ilid_cell
  import ilid_pkg::*;
(
  input  logic             clk,
  input  logic [CMP_W-1:0] idx,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] left,
  input  logic [VAL_W-1:0] right,
  output logic [VAL_W-1:0] data,
  output logic [VAL_W-1:0] rd
);

  logic [VAL_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_WRITE: begin
        if (idx == cmd.pos) data_next = cmd.value;
      end
      OP_SHIFT_R: begin
        if (idx == cmd.pos) data_next = cmd.value;
        else if (idx > cmd.pos) data_next = left;
      end
      OP_SHIFT_L: begin
        if (idx >= cmd.pos) data_next = right;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign rd = (idx == cmd.pos) ? data : '0;

endmodule

/* src/ilid_chain.sv */
// ---------------------------------------------------------------------------
// ilid_chain
// Row of list cells, each wired to both neighbors, with a read-out bus.
// ---------------------------------------------------------------------------
module ilid_chain
  import ilid_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  output logic [VAL_W-1:0] rd
);

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [VAL_W-1:0] cell_rd   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left;
    logic [VAL_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[i+1];
    end

    ilid_cell u_cell (
      .clk   (clk),
      .idx   (CMP_W'(i)),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .data  (cell_data[i]),
      .rd    (cell_rd[i])
    );
  end

  // at most one cell matches the position
  always_comb begin
    rd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd = rd | cell_rd[i];
    end
  end

endmodule

/* src/indexed_list_insert_delete.sv */
// ---------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of 32-bit words with append, insert, delete, clear, read and
// write by index.
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one word per cell; insert and
// delete move every later word one cell over all at once. A word is taken
// whenever the output register is empty or is being read in the same cycle,
// and its result appears on the master side in the next cycle, so a full
// rate of one word per clock is held while the sink keeps tready high. A bad
// position or a full list returns a status and leaves the list untouched.
// No clearing pass is needed after reset.
module indexed_list_insert_delete
  import ilid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] func, [9:3] position, [41:10] value, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_value, [38:32] list_count, [40:39] status, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  logic [2:0]       func;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  logic             accept;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;

  cell_op_t         op;
  cell_cmd_t        cmd;
  logic [VAL_W-1:0] chain_rd;
  logic [VAL_W-1:0] rd_next;
  status_t          st_next;

  logic [VAL_W-1:0] read_value;
  logic [CNT_W-1:0] list_count;
  status_t          status;

  assign func     = s_axis_tdata[2:0];
  assign position = s_axis_tdata[9:3];
  assign value    = s_axis_tdata[41:10];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CNT_W'(CAPACITY));

  always_comb begin
    op         = OP_HOLD;
    count_next = count;
    st_next    = ST_OK;
    rd_next    = '0;
    case (func)
      FN_APPEND: begin
        if (full) st_next = ST_FULL;
        else begin
          op         = OP_WRITE;
          count_next = count + 1'b1;
        end
      end
      FN_INSERT: begin
        if (pos_ext > cnt_ext) st_next = ST_RANGE;
        else if (full) st_next = ST_FULL;
        else begin
          op         = OP_SHIFT_R;
          count_next = count + 1'b1;
        end
      end
      FN_DELETE: begin
        if (pos_ext >= cnt_ext) st_next = ST_RANGE;
        else begin
          op         = OP_SHIFT_L;
          count_next = count - 1'b1;
        end
      end
      FN_CLEAR: begin
        count_next = '0;
      end
      FN_READ: begin
        if (pos_ext >= cnt_ext) st_next = ST_RANGE;
        else rd_next = chain_rd;
      end
      FN_WRITE: begin
        if (pos_ext >= cnt_ext) st_next = ST_RANGE;
        else op = OP_WRITE;
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  assign cmd.op    = accept ? op : OP_HOLD;
  assign cmd.pos   = (func == FN_APPEND) ? cnt_ext : pos_ext;
  assign cmd.value = value;

  ilid_chain u_chain (
    .clk (clk),
    .cmd (cmd),
    .rd  (chain_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) count <= count_next;
      if (accept) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_next;
      list_count <= count_next;
      status     <= st_next;
    end
  end

  assign m_axis_tdata = {7'd0, status, POS_W'(list_count), read_value};

  `include "indexed_list_insert_delete_assert.svh"

  `ILID_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
  `ILID_ASSERT_SAME(a_full_only_at_cap, accept && st_next == ST_FULL, full)
  `ILID_ASSERT_SAME(a_fail_keeps_count, accept && st_next != ST_OK, count_next == count)
  `ILID_ASSERT_NEXT(a_idle_keeps_count, !accept, $stable(count))
  `ILID_ASSERT_NEXT(a_result_follows, accept, m_axis_tvalid && list_count == count)

endmodule

/* tb/sv/list_op_checker.sv */
// ---------------------------------------------------------------------------
// list_op_checker
// Watches both stream channels of the indexed list. Every word taken on the
// slave side is run through a local model of the list, and the expected
// result word is queued. Every word leaving the master side is compared
// field by field with the oldest queued result.
// ---------------------------------------------------------------------------
module list_op_checker
  import ilid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  // [2:0] func, [9:3] position, [41:10] value, [47:42] zero
  input  logic [47:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  // [31:0] read_value, [38:32] list_count, [40:39] status, [47:41] zero
  input  logic [47:0] out_data,
  output int          fail_count,
  output int          pending_results,
  output int          list_len
);

  typedef struct packed {
    logic [6:0]  pad;
    status_t     status;
    logic [6:0]  list_count;
    logic [31:0] read_value;
  } list_result_t;

  logic [31:0]  list_words [CAPACITY];
  int           model_len  = 0;
  int           mismatches = 0;
  list_result_t due_q [$];
  list_result_t want, got;

  assign fail_count      = mismatches;
  assign pending_results = due_q.size();
  assign list_len        = model_len;

  initial begin
    foreach (list_words[i]) list_words[i] = '0;
  end

  // Applies one operation to the local list and returns the result word.
  function automatic list_result_t apply_list_op(input logic [2:0] fn,
                                                 input logic [6:0] pos,
                                                 input logic [31:0] val);
    list_result_t res;
    int           p;
    res = '0;
    res.status = ST_OK;
    p = int'(pos);
    case (fn)
      FN_APPEND: begin
        if (model_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_words[model_len] = val;
          model_len++;
        end
      end
      FN_INSERT: begin
        // position check wins over the full check
        if (p > model_len) begin
          res.status = ST_RANGE;
        end else if (model_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = model_len; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = val;
          model_len++;
        end
      end
      FN_DELETE: begin
        if (p >= model_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < model_len; i++) list_words[i] = list_words[i+1];
          model_len--;
        end
      end
      FN_CLEAR: model_len = 0;
      FN_READ: begin
        if (p >= model_len) res.status = ST_RANGE;
        else res.read_value = list_words[p];
      end
      FN_WRITE: begin
        if (p >= model_len) res.status = ST_RANGE;
        else list_words[p] = val;
      end
      default: ;  // spare codes do nothing
    endcase
    res.list_count = model_len[6:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      model_len = 0;
      due_q.delete();
    end else begin
      // result leaves before the word taken in this cycle is modeled
      if (out_valid && out_ready) begin
        got = out_data;
        if (due_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_data);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, got.read_value);
            mismatches++;
          end
          if (got.list_count !== want.list_count) begin
            $error("list_count: expected %0d, got %0d", want.list_count, got.list_count);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.pad !== want.pad) begin
            $error("pad: expected %h, got %h", want.pad, got.pad);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        due_q.push_back(apply_list_op(in_data[2:0], in_data[9:3], in_data[41:10]));
    end
  end

endmodule

/* tb/sv/tb_indexed_list_insert_delete.sv */
// ---------------------------------------------------------------------------
// tb_indexed_list_insert_delete
// Drives the indexed list with a short directed run over every operation and
// its corner cases, then with random fill, churn and drain phases that reach
// both an empty and a full list. Both sides idle at random; a checker module
// predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_indexed_list_insert_delete;
  import ilid_pkg::*;

  localparam logic [2:0] FN_SPARE6  = 3'd6;
  localparam logic [2:0] FN_SPARE7  = 3'd7;
  localparam int         RAND_WORDS = 550;
  localparam int         MODE_FILL  = 0;
  localparam int         MODE_CHURN = 1;
  localparam int         MODE_DRAIN = 2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  bit          idle_on = 1'b1;
  int          fail_count;
  int          pending_results;
  int          list_len;

  always #5 clk = ~clk;

  indexed_list_insert_delete uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  list_op_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_data        (s_axis_tdata),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_data       (m_axis_tdata),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .list_len       (list_len)
  );

  always @(negedge clk) begin
    m_axis_tready <= !(idle_on && $urandom_range(99) < 20);
  end

  // Called at a falling edge; returns at the falling edge after the word
  // is taken.
  task automatic send_word(input logic [2:0] fn, input logic [6:0] pos,
                           input logic [31:0] val);
    if (idle_on && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while (idle_on && $urandom_range(99) < 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, pos, fn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Called at a falling edge with the source quiet afterwards.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  // last_ok is the highest legal index, or -1 when none is legal
  function automatic logic [6:0] pick_pos(input int last_ok);
    int r;
    r = $urandom_range(99);
    if (last_ok < 0) return (r < 50) ? 7'd0 : 7'($urandom_range(127, 0));
    if (r < 10) return 7'd0;
    if (r < 20) return 7'(last_ok);
    if (r < 85) return 7'($urandom_range(last_ok, 0));
    if (r < 95) return 7'(last_ok + 1);
    return 7'($urandom_range(127, 0));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 32'h8000_0000;
    if (r < 10) return 32'h7fff_ffff;
    if (r < 13) return 32'h0;
    if (r < 16) return 32'hffff_ffff;
    return $urandom();
  endfunction

  initial begin
    int         sent;
    int         seg_len;
    int         mode;
    int         r;
    logic [2:0] fn;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // empty list corners, then a small list
    send_word(FN_READ,   7'd0,   32'h0);
    send_word(FN_DELETE, 7'd0,   32'h1234_5678);
    send_word(FN_WRITE,  7'd0,   32'h5555_5555);
    send_word(FN_INSERT, 7'd1,   32'h1);
    send_word(FN_INSERT, 7'd0,   32'h7fff_ffff);
    send_word(FN_APPEND, 7'd127, 32'h8000_0000);
    send_word(FN_INSERT, 7'd2,   32'hffff_ffff);
    send_word(FN_INSERT, 7'd1,   32'h1234_5678);
    send_word(FN_READ,   7'd0,   32'hffff_ffff);
    send_word(FN_READ,   7'd1,   32'h0);
    send_word(FN_READ,   7'd2,   32'h0);
    send_word(FN_READ,   7'd3,   32'h0);
    send_word(FN_WRITE,  7'd2,   32'ha5a5_a5a5);
    send_word(FN_READ,   7'd2,   32'h0);
    send_word(FN_READ,   7'd4,   32'h0);
    send_word(FN_DELETE, 7'd1,   32'h0);
    send_word(FN_DELETE, 7'd2,   32'h0);
    send_word(FN_READ,   7'd127, 32'h0);
    send_word(FN_SPARE6, 7'd85,  32'hdead_beef);
    send_word(FN_SPARE7, 7'd127, 32'hffff_ffff);
    send_word(FN_CLEAR,  7'd127, 32'hffff_ffff);
    send_word(FN_READ,   7'd0,   32'h0);
    send_word(FN_APPEND, 7'd0,   32'h0);
    send_word(FN_DELETE, 7'd0,   32'h0);
    send_word(FN_INSERT, 7'd0,   32'h5);
    drain_results();

    sent = 0;
    while (sent < RAND_WORDS) begin
      // one long stretch with no idling on either side
      idle_on = !(sent >= 200 && sent < 330);
      mode    = (list_len < 8) ? MODE_FILL : $urandom_range(MODE_DRAIN, MODE_FILL);
      seg_len = $urandom_range(80, 20);
      for (int k = 0; k < seg_len; k++) begin
        r = $urandom_range(99);
        case (mode)
          MODE_FILL: begin
            if (r < 60)      fn = FN_APPEND;
            else if (r < 90) fn = FN_INSERT;
            else if (r < 95) fn = FN_READ;
            else             fn = FN_WRITE;
          end
          MODE_DRAIN: begin
            if (r < 65)      fn = FN_DELETE;
            else if (r < 80) fn = FN_READ;
            else if (r < 90) fn = FN_WRITE;
            else if (r < 97) fn = FN_INSERT;
            else if (r < 98) fn = FN_CLEAR;
            else             fn = (r < 99) ? FN_SPARE6 : FN_SPARE7;
          end
          default: begin
            if (r < 22)      fn = FN_INSERT;
            else if (r < 44) fn = FN_DELETE;
            else if (r < 66) fn = FN_READ;
            else if (r < 86) fn = FN_WRITE;
            else if (r < 94) fn = FN_APPEND;
            else if (r < 96) fn = FN_CLEAR;
            else             fn = (r < 98) ? FN_SPARE6 : FN_SPARE7;
          end
        endcase
        send_word(fn, pick_pos((fn == FN_INSERT) ? list_len : list_len - 1), pick_value());
        sent++;
      end
      if ($urandom_range(3) == 0) drain_results();
    end

    s_axis_tvalid <= 1'b0;
    wait (pending_results == 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/ilid_pkg.sv
src/ilid_cell.sv
src/ilid_chain.sv
src/indexed_list_insert_delete.sv
tb/sv/list_op_checker.sv
tb/sv/tb_indexed_list_insert_delete.sv
